// ===== hw/rtl/hrrn_pkg.sv =====
package hrrn_pkg;

  // Table and field sizes
  localparam int QUEUE_DEPTH = 16;
  localparam int ID_BITS     = 8;
  localparam int BURST_BITS  = 16;
  localparam int TIME_BITS   = 32;
  localparam int IDX_BITS    = $clog2(QUEUE_DEPTH);
  localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);
  localparam int PROD_BITS   = TIME_BITS + BURST_BITS;

  typedef enum logic {
    OP_ARRIVE = 1'b0,
    OP_TICK   = 1'b1
  } op_e;

  typedef struct packed {
    op_e                   op;
    logic [ID_BITS-1:0]    proc_id;
    logic [TIME_BITS-1:0]  arrival_time;
    logic [BURST_BITS-1:0] burst_length;
  } in_t;

  typedef struct packed {
    logic                  run_valid;
    logic [ID_BITS-1:0]    run_id;
    logic [BURST_BITS-1:0] run_remaining;
    logic                  arrival_dropped;
  } out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ARRIVE,
    ST_TICK,
    ST_LOAD0,
    ST_FIRST,
    ST_MUL,
    ST_CMP,
    ST_REMOVE,
    ST_FINISH
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic arrive_commit;
    logic stop_run;
    logic scan_clear;
    logic load_cand;
    logic best_from_cand;
    logic mul;
    logic cmp;
    logic remove;
    logic tick_commit;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic op_tick;
    logic need_pick;
    logic table_empty;
    logic scan_done;
    logic out_free;
  } sts_t;

endpackage

// ===== hw/rtl/hrrn_ctrl.sv =====
module hrrn_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  hrrn_pkg::sts_t sts_i,
  output hrrn_pkg::cmd_t cmd_o
);
  import hrrn_pkg::*;

  state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_ARRIVE;
        end
      end
      ST_ARRIVE: begin
        // Captured op decides the path; arrivals finish here
        if (sts_i.op_tick) begin
          state_d = ST_TICK;
        end else if (sts_i.out_free) begin
          cmd_o.arrive_commit = 1'b1;
          state_d             = ST_IDLE;
        end
      end
      ST_TICK: begin
        if (!sts_i.need_pick) begin
          state_d = ST_FINISH;
        end else if (sts_i.table_empty) begin
          cmd_o.stop_run = 1'b1;
          state_d        = ST_FINISH;
        end else begin
          cmd_o.scan_clear = 1'b1;
          state_d          = ST_LOAD0;
        end
      end
      ST_LOAD0: begin
        cmd_o.load_cand = 1'b1;
        state_d         = ST_FIRST;
      end
      ST_FIRST: begin
        cmd_o.best_from_cand = 1'b1;
        if (sts_i.scan_done) begin
          state_d = ST_REMOVE;
        end else begin
          cmd_o.load_cand = 1'b1;
          state_d         = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_CMP;
      end
      ST_CMP: begin
        // Compare current candidate while fetching the next one
        cmd_o.cmp = 1'b1;
        if (sts_i.scan_done) begin
          state_d = ST_REMOVE;
        end else begin
          cmd_o.load_cand = 1'b1;
          state_d         = ST_MUL;
        end
      end
      ST_REMOVE: begin
        cmd_o.remove = 1'b1;
        state_d      = ST_FINISH;
      end
      ST_FINISH: begin
        if (sts_i.out_free) begin
          cmd_o.tick_commit = 1'b1;
          state_d           = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/hrrn_datapath.sv =====
module hrrn_datapath (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  hrrn_pkg::in_t  in_data_i,
  input  hrrn_pkg::cmd_t cmd_i,
  output hrrn_pkg::sts_t sts_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output hrrn_pkg::out_t out_data_o
);
  import hrrn_pkg::*;

  // Captured transaction
  in_t in_q;

  // Ready table, kept compacted in insertion order
  logic [ID_BITS-1:0]    ent_id_q    [QUEUE_DEPTH];
  logic [TIME_BITS-1:0]  ent_arr_q   [QUEUE_DEPTH];
  logic [BURST_BITS-1:0] ent_burst_q [QUEUE_DEPTH];
  logic [CNT_BITS-1:0]   live_q;

  // Scheduler state
  logic [TIME_BITS-1:0]  elapsed_q;
  logic                  run_valid_q;
  logic [ID_BITS-1:0]    run_id_q;
  logic [BURST_BITS-1:0] run_left_q;

  // Scan registers
  logic [CNT_BITS-1:0]   scan_q;
  logic [IDX_BITS-1:0]   cand_idx_q,   best_idx_q;
  logic [ID_BITS-1:0]    cand_id_q,    best_id_q;
  logic [TIME_BITS-1:0]  cand_arr_q,   best_arr_q;
  logic [BURST_BITS-1:0] cand_burst_q, best_burst_q;
  logic [TIME_BITS-1:0]  cand_wait_q,  best_wait_q;
  logic [PROD_BITS-1:0]  lhs_q, rhs_q, lhs_d, rhs_d;

  // Result register
  logic out_valid_q;
  out_t out_q;

  logic [IDX_BITS-1:0]   rd_idx;
  logic [IDX_BITS-1:0]   wr_idx;
  logic [TIME_BITS-1:0]  rd_arr;
  logic [TIME_BITS-1:0]  rd_wait;
  logic                  drop;
  logic                  outranks;
  logic [BURST_BITS-1:0] left_dec;

  assign rd_idx   = scan_q[IDX_BITS-1:0];
  assign wr_idx   = live_q[IDX_BITS-1:0];
  assign rd_arr   = ent_arr_q[rd_idx];
  // Arrivals from the future wait zero ticks
  assign rd_wait  = (rd_arr > elapsed_q) ? '0 : elapsed_q - rd_arr;
  assign drop     = (in_q.burst_length == '0) || (live_q == CNT_BITS'(QUEUE_DEPTH));
  assign left_dec = run_left_q - BURST_BITS'(1);

  // Cross products of the ratio compare
  always_comb begin
    lhs_d = PROD_BITS'(cand_wait_q) * PROD_BITS'(best_burst_q);
    rhs_d = PROD_BITS'(best_wait_q) * PROD_BITS'(cand_burst_q);
  end

  // Candidate wins on a greater ratio, or an earlier arrival on a tie
  assign outranks = (lhs_q > rhs_q) || ((lhs_q == rhs_q) && (cand_arr_q < best_arr_q));

  // Capture the accepted transaction
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      in_q <= in_data_i;
    end
  end

  // Append an arrival or close the gap left by the picked entry
  always_ff @(posedge clk_i) begin
    if (cmd_i.arrive_commit && !drop) begin
      ent_id_q[wr_idx]    <= in_q.proc_id;
      ent_arr_q[wr_idx]   <= in_q.arrival_time;
      ent_burst_q[wr_idx] <= in_q.burst_length;
    end else if (cmd_i.remove) begin
      for (int k = 0; k < QUEUE_DEPTH - 1; k++) begin
        if (IDX_BITS'(k) >= best_idx_q) begin
          ent_id_q[k]    <= ent_id_q[k+1];
          ent_arr_q[k]   <= ent_arr_q[k+1];
          ent_burst_q[k] <= ent_burst_q[k+1];
        end
      end
    end
  end

  // Fill count, running process, tick count and scan index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q      <= '0;
      elapsed_q   <= '0;
      run_valid_q <= 1'b0;
      run_id_q    <= '0;
      run_left_q  <= '0;
      scan_q      <= '0;
    end else begin
      if (cmd_i.arrive_commit && !drop) begin
        live_q <= live_q + CNT_BITS'(1);
      end
      if (cmd_i.stop_run) begin
        run_valid_q <= 1'b0;
      end
      if (cmd_i.remove) begin
        live_q      <= live_q - CNT_BITS'(1);
        run_valid_q <= 1'b1;
        run_id_q    <= best_id_q;
        run_left_q  <= best_burst_q;
      end
      if (cmd_i.tick_commit) begin
        if (run_valid_q) begin
          run_left_q <= left_dec;
        end
        elapsed_q <= elapsed_q + TIME_BITS'(1);
      end
      if (cmd_i.scan_clear) begin
        scan_q <= '0;
      end else if (cmd_i.load_cand) begin
        scan_q <= scan_q + CNT_BITS'(1);
      end
    end
  end

  // Candidate fetch, products and best-so-far
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_cand) begin
      cand_idx_q   <= rd_idx;
      cand_id_q    <= ent_id_q[rd_idx];
      cand_arr_q   <= rd_arr;
      cand_burst_q <= ent_burst_q[rd_idx];
      cand_wait_q  <= rd_wait;
    end
    if (cmd_i.mul) begin
      lhs_q <= lhs_d;
      rhs_q <= rhs_d;
    end
    if (cmd_i.best_from_cand || (cmd_i.cmp && outranks)) begin
      best_idx_q   <= cand_idx_q;
      best_id_q    <= cand_id_q;
      best_arr_q   <= cand_arr_q;
      best_burst_q <= cand_burst_q;
      best_wait_q  <= cand_wait_q;
    end
  end

  // Result register: valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.arrive_commit || cmd_i.tick_commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result register: payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.arrive_commit) begin
      out_q.run_valid       <= 1'b0;
      out_q.run_id          <= '0;
      out_q.run_remaining   <= '0;
      out_q.arrival_dropped <= drop;
    end else if (cmd_i.tick_commit) begin
      out_q.run_valid       <= run_valid_q;
      out_q.run_id          <= run_valid_q ? run_id_q : '0;
      out_q.run_remaining   <= run_valid_q ? left_dec : '0;
      out_q.arrival_dropped <= 1'b0;
    end
  end

  assign sts_o.op_tick     = (in_q.op == OP_TICK);
  assign sts_o.need_pick   = !run_valid_q || (run_left_q == '0);
  assign sts_o.table_empty = (live_q == '0);
  assign sts_o.scan_done   = (scan_q == live_q);
  assign sts_o.out_free    = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== hw/rtl/hrrn_process_scheduler.sv =====
// Non-preemptive highest-response-ratio-next scheduler with a 16-entry ready
// table. Each input transaction is either an arrival, which appends a process
// to the table (flagged as dropped if the table is full or the burst is zero),
// or a tick, which picks the waiting process with the greatest
// (wait + burst) / burst when nothing is running, runs the current process for
// one tick and reports it. Ratios are compared exactly by 32x16 cross
// products; ties go to the earliest arrival time, then to the older entry.
// One transaction is handled at a time. An arrival is committed from the
// arrive state; a tick that needs no new pick, or finds the table empty, goes
// straight to the finish state. A tick that picks from N waiting entries first
// runs the selection scan: the first entry is loaded as best, each further
// entry passes in turn through the shared multiply and compare stages, and the
// chosen entry is then removed from the table. The next transaction is
// accepted in the cycle after the result is loaded. A result waits in an
// output register, so the next transaction is accepted while the previous
// result is still held; a new result is loaded only once that one is taken.
module hrrn_process_scheduler (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  hrrn_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output hrrn_pkg::out_t out_data_o
);
  import hrrn_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencer
  hrrn_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Table, scan and result registers
  hrrn_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== hw/rtl/hrrn_chk.sv =====
module hrrn_chk (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_i,
  input logic           out_valid_i,
  input logic           out_ready_i,
  input hrrn_pkg::out_t out_data_i
);
  import hrrn_pkg::*;

  // Hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("stalled result changed or dropped");

  // Take one transaction at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("second transaction accepted while busy");

  // Never raise a result in the cycle right after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !$rose(out_valid_i))
    else $error("result appeared too early after accept");

endmodule

bind hrrn_process_scheduler hrrn_chk u_hrrn_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_i  (in_ready_o),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_i  (out_data_o)
);
